@@ hdl/ssms_pkg.sv @@
package ssms_pkg;

    localparam int SSMS_NUM_STACKS    = 16;
    localparam int SSMS_STORE_DEPTH   = 64;
    localparam int SSMS_ELEMENT_WIDTH = 16;

    // wide enough for any slot pointer up to the largest store, plus one
    localparam int PTR_W = 13;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [3:0]  stack_index;
        logic [15:0] push_data;
    } cmd_t;

    typedef struct packed {
        logic [15:0] pop_data;
        logic        empty_flag;
        logic        full_flag;
        logic [6:0]  stack_size;
    } rsp_t;

    typedef struct packed {
        logic             shift_up;
        logic             shift_down;
        logic             write;
        logic [PTR_W-1:0] lo;
        logic [PTR_W-1:0] hi;
        logic [PTR_W-1:0] wr_addr;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SHIFT,
        ST_EXEC
    } state_t;

endpackage

@@ hdl/ssms_cell.sv @@
module ssms_cell
    import ssms_pkg::*;
#(
    parameter int IDX           = 0,
    parameter int ELEMENT_WIDTH = SSMS_ELEMENT_WIDTH
)
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic [ELEMENT_WIDTH-1:0] wr_data,
    input  logic [ELEMENT_WIDTH-1:0] below,
    input  logic [ELEMENT_WIDTH-1:0] above,
    output logic [ELEMENT_WIDTH-1:0] q
);

    localparam logic [PTR_W-1:0] MY_IDX = PTR_W'(IDX);

    logic [ELEMENT_WIDTH-1:0] q_reg;
    logic [ELEMENT_WIDTH-1:0] q_next;
    logic                     in_range;

    assign in_range = (MY_IDX >= ctrl.lo) && (MY_IDX <= ctrl.hi);

    always_comb
    begin
        q_next = q_reg;
        if (ctrl.write && (ctrl.wr_addr == MY_IDX))
        begin
            q_next = wr_data;
        end
        else if (ctrl.shift_up && in_range)
        begin
            q_next = below;
        end
        else if (ctrl.shift_down && in_range)
        begin
            q_next = above;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

@@ hdl/ssms_cell_row.sv @@
module ssms_cell_row
    import ssms_pkg::*;
#(
    parameter int STORE_DEPTH   = SSMS_STORE_DEPTH,
    parameter int ELEMENT_WIDTH = SSMS_ELEMENT_WIDTH,
    localparam int PW           = $clog2(STORE_DEPTH + 1)
)
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic [ELEMENT_WIDTH-1:0] wr_data,
    input  logic [PW-1:0]            rd_addr,
    output logic [ELEMENT_WIDTH-1:0] rd_data
);

    logic [ELEMENT_WIDTH-1:0] cell_q [STORE_DEPTH+1];
    logic [ELEMENT_WIDTH-1:0] rd_data_reg;

    for (genvar m = 0; m <= STORE_DEPTH; m++)
    begin : g_cell
        logic [ELEMENT_WIDTH-1:0] below;
        logic [ELEMENT_WIDTH-1:0] above;

        if (m == 0)
        begin : g_first
            assign below = '0;
        end
        else
        begin : g_mid_lo
            assign below = cell_q[m-1];
        end

        if (m == STORE_DEPTH)
        begin : g_last
            assign above = '0;
        end
        else
        begin : g_mid_hi
            assign above = cell_q[m+1];
        end

        ssms_cell #(
            .IDX           (m),
            .ELEMENT_WIDTH (ELEMENT_WIDTH)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .wr_data (wr_data),
            .below   (below),
            .above   (above),
            .q       (cell_q[m])
        );
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= cell_q[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/shared_store_multi_stack.sv @@
// channel | direction | handshake          | payload
// cmd     | in        | cmd_valid/cmd_ready | cmd_t {func, stack_index, push_data}
// rsp     | out       | rsp_valid/rsp_ready | rsp_t {pop_data, empty_flag, full_flag, stack_size}
//
// One item at a time: after accept the item is evaluated (search state), the cell
// row is shifted once when a neighboring stack must be moved, and the result
// register loads in the execute state. The next item is taken only back in idle.
// The shift moves every affected slot at once along the cell row.
// Reset restores the initial bases and tops; store contents are not cleared.
// A stalled result holds the block in its final step; cmd_ready is low until done.
module shared_store_multi_stack
    import ssms_pkg::*;
#(
    parameter int NUM_STACKS    = SSMS_NUM_STACKS,
    parameter int STORE_DEPTH   = SSMS_STORE_DEPTH,
    parameter int ELEMENT_WIDTH = SSMS_ELEMENT_WIDTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int PW = $clog2(STORE_DEPTH + 1);

    state_t state_reg;
    state_t state_next;

    cmd_t             item_reg;
    logic [PW-1:0]    base_reg [NUM_STACKS];
    logic [PW-1:0]    top_reg  [NUM_STACKS];
    logic             up_reg;
    logic             dn_reg;
    logic             full_reg;
    logic [SW-1:0]    slo_reg;
    logic [SW-1:0]    shi_reg;
    logic [PTR_W-1:0] clo_reg;
    logic [PTR_W-1:0] chi_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_valid_reg;

    logic [NUM_STACKS-1:0]    room;
    logic [SW-1:0]            sidx;
    logic [SW-1:0]            i1;
    logic [SW-1:0]            lc1;
    logic                     idx_ok;
    logic                     is_push;
    logic                     rfound;
    logic                     lfound;
    logic [SW-1:0]            rj;
    logic [SW-1:0]            lc;
    logic                     need_shift;
    logic                     proceed;
    logic                     push_ok;
    logic                     pop_empty;
    logic [PW-1:0]            cur_top;
    logic [PW-1:0]            cur_base;
    logic [PW-1:0]            new_size;
    cell_ctrl_t               ctrl;
    logic [ELEMENT_WIDTH-1:0] rd_data;

    assign sidx     = SW'(item_reg.stack_index);
    assign idx_ok   = 32'(item_reg.stack_index) < NUM_STACKS;
    assign is_push  = item_reg.func == FUNC_PUSH;
    assign i1       = sidx + 1'b1;
    assign lc1      = lc + 1'b1;
    assign cur_top  = top_reg[sidx];
    assign cur_base = base_reg[sidx];
    assign proceed  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        for (int k = 0; k < NUM_STACKS; k++)
        begin
            if (k < NUM_STACKS - 1)
            begin
                room[k] = top_reg[k] < base_reg[(k + 1) % NUM_STACKS];
            end
            else
            begin
                room[k] = top_reg[k] < PW'(STORE_DEPTH);
            end
        end
    end

    always_comb
    begin
        rfound = 1'b0;
        rj     = '0;
        for (int k = NUM_STACKS - 1; k >= 0; k--)
        begin
            if ((SW'(k) > sidx) && room[k])
            begin
                rfound = 1'b1;
                rj     = SW'(k);
            end
        end
    end

    always_comb
    begin
        lfound = 1'b0;
        lc     = '0;
        for (int k = 0; k < NUM_STACKS; k++)
        begin
            if ((SW'(k) < sidx) && room[k])
            begin
                lfound = 1'b1;
                lc     = SW'(k);
            end
        end
    end

    assign need_shift = is_push && idx_ok && !room[sidx];
    assign push_ok    = is_push && idx_ok && !full_reg;
    assign pop_empty  = cur_top == cur_base;

    always_comb
    begin
        if (push_ok)
        begin
            new_size = cur_top - cur_base + 1'b1;
        end
        else if (!is_push && !pop_empty)
        begin
            new_size = cur_top - cur_base - 1'b1;
        end
        else
        begin
            new_size = cur_top - cur_base;
        end
    end

    always_comb
    begin
        rsp_next = '0;
        if (idx_ok)
        begin
            rsp_next.full_flag  = is_push && full_reg;
            rsp_next.empty_flag = !is_push && pop_empty;
            rsp_next.pop_data   = (!is_push && !pop_empty) ? 16'(rd_data) : 16'd0;
            rsp_next.stack_size = 7'(new_size);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (need_shift && (rfound || lfound))
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_SHIFT:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (proceed)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        ctrl      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            ST_EVAL:
            begin
            end
            ST_SHIFT:
            begin
                ctrl.shift_up   = up_reg;
                ctrl.shift_down = dn_reg;
                ctrl.lo         = clo_reg;
                ctrl.hi         = chi_reg;
            end
            ST_EXEC:
            begin
                ctrl.write   = proceed && push_ok;
                ctrl.wr_addr = PTR_W'(cur_top) + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            up_reg        <= 1'b0;
            dn_reg        <= 1'b0;
            full_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_STACKS; k++)
            begin
                base_reg[k] <= PW'((k * STORE_DEPTH) / NUM_STACKS);
                top_reg[k]  <= PW'((k * STORE_DEPTH) / NUM_STACKS);
            end
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_EXEC) && proceed)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                end
                ST_EVAL:
                begin
                    up_reg   <= need_shift && rfound;
                    dn_reg   <= need_shift && !rfound && lfound;
                    full_reg <= need_shift && !rfound && !lfound;
                end
                ST_SHIFT:
                begin
                    for (int k = 0; k < NUM_STACKS; k++)
                    begin
                        if ((SW'(k) >= slo_reg) && (SW'(k) <= shi_reg))
                        begin
                            if (up_reg)
                            begin
                                base_reg[k] <= base_reg[k] + 1'b1;
                                top_reg[k]  <= top_reg[k] + 1'b1;
                            end
                            else
                            begin
                                base_reg[k] <= base_reg[k] - 1'b1;
                                top_reg[k]  <= top_reg[k] - 1'b1;
                            end
                        end
                    end
                end
                ST_EXEC:
                begin
                    if (proceed)
                    begin
                        if (push_ok)
                        begin
                            top_reg[sidx] <= cur_top + 1'b1;
                        end
                        else if (idx_ok && !is_push && !pop_empty)
                        begin
                            top_reg[sidx] <= cur_top - 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            item_reg <= cmd;
        end
        if (state_reg == ST_EVAL)
        begin
            if (rfound)
            begin
                slo_reg <= i1;
                shi_reg <= rj;
                clo_reg <= PTR_W'(base_reg[i1]) + PTR_W'(2);
                chi_reg <= PTR_W'(top_reg[rj]) + 1'b1;
            end
            else
            begin
                slo_reg <= lc1;
                shi_reg <= sidx;
                clo_reg <= PTR_W'(base_reg[lc1]);
                chi_reg <= PTR_W'(cur_top) - 1'b1;
            end
        end
        if ((state_reg == ST_EXEC) && proceed)
        begin
            rsp_reg <= rsp_next;
        end
    end

    ssms_cell_row #(
        .STORE_DEPTH   (STORE_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_row (
        .clk     (clk),
        .ctrl    (ctrl),
        .wr_data (ELEMENT_WIDTH'(item_reg.push_data)),
        .rd_addr (cur_top),
        .rd_data (rd_data)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_base0_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg[0] == '0)
        else $error("stack 0 base moved");

    a_last_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg[NUM_STACKS-1] <= PW'(STORE_DEPTH))
        else $error("last stack top beyond store");

    a_shift_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHIFT |=> state_reg == ST_EXEC)
        else $error("shift not followed by execute");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.full_flag && rsp_reg.empty_flag))
        else $error("full and empty both set");

    a_shift_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
        !(up_reg && dn_reg))
        else $error("shift in both directions");

endmodule
